// ===== rtl/psi_pkg.sv =====
// Shared types and constants for the pointing schedule interpolator.
package psi_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam logic [31:0] REFETCH_AGE = 32'd86400;
    localparam int AZ_W = 16;
    localparam int EL_W = 15;
    localparam int QUO_W = 48;
    localparam logic signed [18:0] FULL_TURN = 19'sd46080;
    localparam logic signed [18:0] HALF_TURN = 19'sd23040;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_SCHED_START = 3'd0;
    localparam logic [2:0] REG_SCHED_STOP  = 3'd1;
    localparam logic [2:0] REG_FETCHED_AT  = 3'd2;
    localparam logic [2:0] REG_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_SAMPLE_CNT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_CALC,
        ST_OUT
    } psi_state_t;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic rd_sel;
        logic latch0;
        logic latch1;
        logic calc;
        logic finish;
        logic out_clear;
    } psi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_query;
        logic out_full;
    } psi_stat_t;
endpackage

// ===== rtl/psi_ram.sv =====
// Generic single-port RAM with registered read.
module psi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/psi_ctrl.sv =====
// Controller state machine sequencing write, commit and query transactions.
module psi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  psi_pkg::psi_stat_t stat,
    input  logic               out_take,
    output psi_pkg::psi_cmd_t  cmd
);
    import psi_pkg::*;

    psi_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        cmd.out_clear = out_take;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!stat.is_query)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.div_done)
                begin
                    state_next = ST_RD0;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_RD0:
            begin
                cmd.rd_sel = 1'b1;
                cmd.latch0 = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.latch1 = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the result register is free
                if (!stat.out_full || out_take)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/psi_dp.sv =====
// Datapath: registers, sample tables, restoring divider and interpolation.
module psi_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psi_pkg::psi_cmd_t             cmd,
    output psi_pkg::psi_stat_t            stat,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic [1:0]                    in_cmd,
    input  logic [psi_pkg::ADDR_W-1:0]    in_index,
    input  logic [psi_pkg::AZ_W-1:0]      in_az,
    input  logic signed [psi_pkg::EL_W-1:0] in_el,
    input  logic [31:0]                   in_now,
    output logic                          out_valid,
    output logic                          ok,
    output logic [psi_pkg::AZ_W-1:0]      az_out,
    output logic signed [psi_pkg::EL_W-1:0] el_out,
    output logic                          is_current,
    output logic                          fetch_due
);
    import psi_pkg::*;

    logic [31:0] sched_start_reg, sched_stop_reg, fetched_at_reg;
    logic [15:0] interval_reg;
    logic [10:0] sample_cnt_reg;
    logic        loaded_reg;

    logic [1:0]        cmd_reg;
    logic [31:0]       now_reg;

    logic [QUO_W-1:0] quo_reg;
    logic [16:0]      rem_reg;
    logic [5:0]       cnt_reg;

    logic [AZ_W-1:0] a0_reg;
    logic signed [EL_W-1:0] e0_reg;
    logic clamp_reg;
    logic signed [35:0] az_prod_reg, el_prod_reg;

    logic ok_reg, cur_reg, due_reg, out_valid_reg;
    logic [AZ_W-1:0] az_reg;
    logic [EL_W-1:0] el_reg;

    logic cnt_ok;
    assign cnt_ok = sample_cnt_reg >= 11'd1 && sample_cnt_reg <= 11'(TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_start_reg <= '0;
            sched_stop_reg  <= '0;
            fetched_at_reg  <= '0;
            interval_reg    <= 16'd1;
            sample_cnt_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCHED_START: sched_start_reg <= cfg_data;
                REG_SCHED_STOP:  sched_stop_reg  <= cfg_data;
                REG_FETCHED_AT:  fetched_at_reg  <= cfg_data;
                REG_INTERVAL:    interval_reg    <= cfg_data[15:0];
                REG_SAMPLE_CNT:  sample_cnt_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // divider: dividend t<<16, 48 quotient bits
    logic [31:0] t_val;
    logic [15:0] ivl;
    logic [16:0] rem_sh;
    logic        dbit;
    assign t_val  = (now_reg > sched_start_reg) ? now_reg - sched_start_reg : 32'd0;
    assign ivl    = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
    assign rem_sh = {rem_reg[15:0], quo_reg[QUO_W-1]};
    assign dbit   = rem_sh >= {1'b0, ivl};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg   <= in_cmd;
            now_reg   <= in_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            cnt_reg <= 6'd0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (cnt_reg == 6'd0)
            begin
                quo_reg <= {t_val, 16'd0};
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= dbit ? rem_sh - {1'b0, ivl} : rem_sh;
                quo_reg <= {quo_reg[QUO_W-2:0], dbit};
            end
        end
    end

    assign stat.div_done = cnt_reg == 6'(QUO_W + 1);
    assign stat.is_query = cmd_reg == CMD_QUERY;
    assign stat.out_full = out_valid_reg;

    logic [31:0] i0;
    logic [10:0] last;
    logic        clamp;
    assign i0    = quo_reg[QUO_W-1:16];
    assign last  = sample_cnt_reg - 11'd1;
    assign clamp = i0 >= {21'd0, last};

    logic [ADDR_W-1:0] rd_addr, ram_addr;
    logic ram_we;
    assign rd_addr  = clamp ? last[ADDR_W-1:0] : (cmd.rd_sel ? i0[ADDR_W-1:0]
                                                             : i0[ADDR_W-1:0] + ADDR_W'(1));
    assign ram_we   = cmd.load_item && in_cmd == CMD_WRITE;
    assign ram_addr = ram_we ? in_index : rd_addr;

    logic [AZ_W-1:0] az_rd;
    logic [EL_W-1:0] el_rd;

    psi_ram #(.WIDTH(AZ_W), .DEPTH(TABLE_DEPTH)) u_az_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_az),
        .rdata (az_rd)
    );

    psi_ram #(.WIDTH(EL_W), .DEPTH(TABLE_DEPTH)) u_el_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_el),
        .rdata (el_rd)
    );

    // reads: address applied in RD0 returns in RD1, second in CALC
    always_ff @(posedge clk)
    begin
        if (cmd.latch0)
        begin
            clamp_reg <= clamp;
        end
        if (cmd.latch1)
        begin
            a0_reg <= az_rd;
            e0_reg <= el_rd;
        end
    end

    logic signed [18:0] d_az, d_az_w;
    logic signed [16:0] d_el;
    logic signed [17:0] frac_s;
    assign d_az   = $signed({3'b0, az_rd}) - $signed({3'b0, a0_reg});
    assign d_az_w = (d_az > HALF_TURN) ? d_az - FULL_TURN :
                    (d_az < -HALF_TURN) ? d_az + FULL_TURN : d_az;
    assign d_el   = $signed({el_rd[EL_W-1], el_rd[EL_W-1], el_rd})
                  - $signed({e0_reg[EL_W-1], e0_reg[EL_W-1], e0_reg});
    assign frac_s = $signed({2'b0, quo_reg[15:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            az_prod_reg <= d_az_w * frac_s + 36'sd32768;
            el_prod_reg <= d_el * frac_s + 36'sd32768;
        end
    end

    // arithmetic shift equals floor, matching round-half-up
    logic signed [19:0] az_sum, az_wrap;
    logic signed [17:0] el_sum;
    assign az_sum  = $signed({4'b0, a0_reg}) + 20'(az_prod_reg >>> 16);
    assign az_wrap = (az_sum < 0) ? az_sum + 20'sd46080 :
                     (az_sum >= 20'sd46080) ? az_sum - 20'sd46080 : az_sum;
    assign el_sum  = 18'($signed(e0_reg)) + 18'(el_prod_reg >>> 16);

    logic cur_q, due_q;
    assign cur_q = loaded_reg && now_reg >= sched_start_reg && now_reg < sched_stop_reg;
    assign due_q = !loaded_reg || now_reg >= sched_stop_reg ||
                   (now_reg > fetched_at_reg && now_reg - fetched_at_reg >= REFETCH_AGE);

    logic ok_next, cur_next, due_next;
    logic [AZ_W-1:0] az_next;
    logic [EL_W-1:0] el_next;

    always_comb
    begin
        ok_next  = 1'b0;
        az_next  = '0;
        el_next  = '0;
        cur_next = 1'b0;
        due_next = 1'b0;
        case (cmd_reg)
            CMD_WRITE:  ok_next = 1'b1;
            CMD_COMMIT: ok_next = cnt_ok;
            CMD_QUERY:
            begin
                cur_next = cur_q;
                due_next = due_q;
                if (loaded_reg && cnt_ok)
                begin
                    ok_next = 1'b1;
                    az_next = clamp_reg ? a0_reg : az_wrap[AZ_W-1:0];
                    el_next = clamp_reg ? e0_reg : el_sum[EL_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            loaded_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
            if (cmd_reg == CMD_COMMIT && cnt_ok)
            begin
                loaded_reg <= 1'b1;
            end
        end
        else if (cmd.out_clear)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg  <= ok_next;
            az_reg  <= az_next;
            el_reg  <= el_next;
            cur_reg <= cur_next;
            due_reg <= due_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign az_out     = az_reg;
    assign el_out     = el_reg;
    assign is_current = cur_reg;
    assign fetch_due  = due_reg;
endmodule

// ===== rtl/pointing_schedule_interpolator.sv =====
// Top level of the pointing schedule interpolator.
// One transaction at a time. A write or commit passes through the DIV and OUT
// states before the next acceptance, its result registered as it leaves OUT; a
// query steps through a divider load, 48 shift-subtract steps of the 48-bit
// quotient and a done check, two table reads, one multiply stage and the
// result write. The result register lets the next transaction start while a
// finished result waits; that transaction then holds in its OUT state until
// the register is taken. Configure only while idle.
module pointing_schedule_interpolator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [psi_pkg::ADDR_W-1:0]      index,
    input  logic [psi_pkg::AZ_W-1:0]        az_in,
    input  logic signed [psi_pkg::EL_W-1:0] el_in,
    input  logic [31:0]                     now,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            ok,
    output logic [psi_pkg::AZ_W-1:0]        az_out,
    output logic signed [psi_pkg::EL_W-1:0] el_out,
    output logic                            is_current,
    output logic                            fetch_due
);
    import psi_pkg::*;

    psi_cmd_t  ctl;
    psi_stat_t stat;

    assign cfg_ready = 1'b1;

    psi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .out_take (out_valid && !out_stall),
        .cmd      (ctl)
    );

    psi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl),
        .stat       (stat),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (cmd),
        .in_index   (index),
        .in_az      (az_in),
        .in_el      (el_in),
        .in_now     (now),
        .out_valid  (out_valid),
        .ok         (ok),
        .az_out     (az_out),
        .el_out     (el_out),
        .is_current (is_current),
        .fetch_due  (fetch_due)
    );
endmodule

// ===== rtl/psi_checker.sv =====
// Port-level checker for the pointing schedule interpolator.
module psi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] cmd,
    input logic       out_valid,
    input logic       out_stall,
    input logic       ok,
    input logic       is_current,
    input logic       fetch_due
);
    import psi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({ok, is_current, fetch_due}))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_WRITE && !out_valid |-> ##3 (out_valid && ok))
        else $error("write result missing");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake unknown");
endmodule

bind pointing_schedule_interpolator psi_checker u_psi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .is_current (is_current),
    .fetch_due  (fetch_due)
);
